// ----- design/block_allocator_next_fit_core_macros.svh -----
// Assertion macros shared by the block allocator RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef BLOCK_ALLOCATOR_NEXT_FIT_CORE_MACROS_SVH
`define BLOCK_ALLOCATOR_NEXT_FIT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ba_pkg.sv -----
// Block allocator package: sizes, codes and controller/datapath structs.
// No dependencies.
`default_nettype none

package ba_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int WORD_W     = 32;
   localparam int WORD_NUM   = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int WADDR_W    = $clog2(WORD_NUM);
   localparam int BLK_W      = BIT_W + WADDR_W;
   localparam int HINT_W     = $clog2(NUM_BLOCKS + 1);

   // transaction field widths
   localparam int OP_W     = 1;
   localparam int IDX_W    = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
   localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

   typedef struct packed {
      logic start;   // capture request, read first word
      logic next;    // read the following bitmap word
      logic commit;  // update state and load the response register
   } ba_cmd_type;

   typedef struct packed {
      logic op_release;  // captured request is a release
      logic found;       // current word has a free bit at or above the hint
      logic last_word;   // current word is the last one of the bitmap
      logic hint_end;    // hint is past the last block
      logic rsp_busy;    // response register full and not being taken
   } ba_stat_type;

endpackage

`default_nettype wire

// ----- design/ba_req_if.sv -----
// Request channel: valid/ready plus operation and block index.
// Depends on ba_pkg.
`default_nettype none

interface ba_req_if
   import ba_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [IDX_W-1:0]   block_index;

   modport source (output valid, output operation, output block_index, input ready);
   modport sink   (input valid, input operation, input block_index, output ready);
endinterface

`default_nettype wire

// ----- design/ba_rsp_if.sv -----
// Response channel: valid/ready plus result index, status and free count.
// Depends on ba_pkg.
`default_nettype none

interface ba_rsp_if
   import ba_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [IDX_W-1:0]      result_index;
   logic [STATUS_W-1:0]   status;
   logic [COUNT_W-1:0]    free_blocks;

   modport source (output valid, output result_index, output status, output free_blocks,
                   input ready);
   modport sink   (input valid, input result_index, input status, input free_blocks,
                   output ready);
endinterface

`default_nettype wire

// ----- design/ba_datapath.sv -----
// Allocator datapath: bitmap word memory, hint, free count, response register.
// Depends on ba_pkg and the assertion macro header.
`default_nettype none
`include "block_allocator_next_fit_core_macros.svh"

module ba_datapath
   import ba_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [IDX_W-1:0]     req_block_index,
   input  wire ba_cmd_type           cmd,
   output ba_stat_type               stat,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [IDX_W-1:0]          rsp_result_index,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_free_blocks
);

   // bitmap storage; a row never written reads as all free
   logic [WORD_W-1:0]   mem [WORD_NUM];
   logic [WORD_NUM-1:0] row_valid_ff;

   logic [WORD_W-1:0]   rd_data_ff;
   logic                rd_valid_ff;
   logic [WADDR_W-1:0]  addr_ff, rd_addr;
   logic                first_ff;
   logic [OP_W-1:0]     op_ff;
   logic [BLK_W-1:0]    idx_ff;
   logic [HINT_W-1:0]   hint_ff, hint_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [WORD_W-1:0]   raw_word, lower_mask, eff_word, wr_word;
   logic [BIT_W-1:0]    pos;
   logic                found;
   logic                wr_en;
   logic                range_err;
   logic                bit_used;
   logic                alloc_hit;
   logic [BIT_W-1:0]    rel_bit;
   logic [IDX_W-1:0]    res_index;
   logic [STATUS_W-1:0] res_status;

   assign raw_word   = rd_valid_ff ? rd_data_ff : '0;
   assign lower_mask = first_ff ? ((WORD_W'(1) << hint_ff[BIT_W-1:0]) - WORD_W'(1)) : '0;
   assign eff_word   = raw_word | lower_mask;

   // lowest free bit of the masked word
   always_comb begin
      pos   = '0;
      found = 1'b0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!eff_word[i]) begin
            pos   = BIT_W'(i);
            found = 1'b1;
         end
      end
   end

   assign stat.op_release = (op_ff == OP_RELEASE);
   assign stat.found      = found;
   assign stat.last_word  = (addr_ff == WADDR_W'(WORD_NUM - 1));
   assign stat.hint_end   = (hint_ff >= HINT_W'(NUM_BLOCKS));
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   always_comb begin
      if (!cmd.start) begin
         rd_addr = addr_ff + WADDR_W'(1);
      end else if (req_operation == OP_RELEASE) begin
         rd_addr = req_block_index[BLK_W-1:BIT_W];
      end else begin
         rd_addr = hint_ff[BLK_W-1:BIT_W];
      end
   end

   assign rel_bit   = idx_ff[BIT_W-1:0];
   assign range_err = ({1'b0, idx_ff} >= (BLK_W + 1)'(NUM_BLOCKS));
   assign bit_used  = raw_word[rel_bit];
   assign alloc_hit = found && !stat.hint_end;

   // outcome of the current transaction at commit
   always_comb begin
      wr_en      = 1'b0;
      wr_word    = raw_word;
      hint_in    = hint_ff;
      count_in   = count_ff;
      res_index  = '0;
      res_status = ST_OK;
      if (op_ff == OP_ALLOC) begin
         if (alloc_hit) begin
            wr_en     = 1'b1;
            wr_word   = raw_word | (WORD_W'(1) << pos);
            hint_in   = HINT_W'({addr_ff, pos}) + HINT_W'(1);
            count_in  = (count_ff != '0) ? count_ff - COUNT_W'(1) : count_ff;
            res_index = IDX_W'({addr_ff, pos});
         end else begin
            res_status = ST_NONE_FREE;
         end
      end else if (range_err) begin
         res_status = ST_RANGE;
      end else if (!bit_used) begin
         res_status = ST_ALREADY_FREE;
      end else begin
         wr_en    = 1'b1;
         wr_word  = raw_word & ~(WORD_W'(1) << rel_bit);
         hint_in  = (hint_ff > HINT_W'(idx_ff)) ? HINT_W'(idx_ff) : hint_ff;
         count_in = (count_ff < COUNT_W'(NUM_BLOCKS)) ? count_ff + COUNT_W'(1) : count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         mem[addr_ff] <= wr_word;
      end
      if (cmd.start || cmd.next) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         hint_ff      <= '0;
         count_ff     <= COUNT_W'(NUM_BLOCKS);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start || cmd.next) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         if (cmd.commit) begin
            if (wr_en) begin
               row_valid_ff[addr_ff] <= 1'b1;
            end
            hint_ff      <= hint_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_operation;
         idx_ff   <= BLK_W'(req_block_index);
         first_ff <= 1'b1;
      end else if (cmd.next) begin
         first_ff <= 1'b0;
      end
      if (cmd.start || cmd.next) begin
         addr_ff <= rd_addr;
      end
      if (cmd.commit) begin
         rsp_index_ff  <= res_index;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_free_blocks  = count_ff;

   `BA_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(NUM_BLOCKS), "free count past block total")
   `BA_ASSERT_IMPL(a_hint_bound, clock, reset, 1'b1, hint_ff <= HINT_W'(NUM_BLOCKS), "hint past end of bitmap")
   `BA_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.commit, !stat.rsp_busy, "response overwritten before taken")
   `BA_ASSERT_NEXT(a_alloc_count, clock, reset, cmd.commit && (op_ff == OP_ALLOC) && alloc_hit, count_ff == $past(count_ff) - COUNT_W'(1), "allocate did not take one block")

endmodule

`default_nettype wire

// ----- design/ba_ctrl.sv -----
// Allocator controller: sequences request capture, word scan and commit.
// Depends on ba_pkg.
`default_nettype none

module ba_ctrl
   import ba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ba_stat_type stat,
   output ba_cmd_type       cmd
);

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } state_type;

   state_type state_ff, state_in;
   logic      done;

   // release needs one word; allocate ends on a hit, at the last word or past the end
   assign done = stat.op_release || stat.hint_end || stat.found || stat.last_word;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!done) begin
               cmd.next = 1'b1;
            end else if (!stat.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/block_allocator_next_fit_core.sv -----
// Block allocator top level: next-fit bitmap allocator with first-free hint.
// Depends on ba_pkg, ba_req_if, ba_rsp_if, ba_ctrl and ba_datapath.
//
//   channel | dir | fields                                   | handshake
//   --------+-----+------------------------------------------+-----------
//   req     | in  | operation, block_index                   | valid/ready
//   rsp     | out | result_index, status, free_blocks        | valid/ready
//
// Release: capture and word read, then commit.
// Allocate: capture and hint word read, scan of words past it (0..31) reading
//   one 32-bit word a cycle from the single-port bitmap memory, then commit.
// Reset: synchronous; per-row valid bits mark the whole bitmap free at once,
//   no clearing pass.
// A full response register stalls commit only; the next request is taken
//   while an earlier response still waits on rsp.ready.
`default_nettype none

module block_allocator_next_fit_core
   import ba_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ba_req_if.sink     req,
   ba_rsp_if.source   rsp
);

   ba_cmd_type  cmd;
   ba_stat_type stat;

   // sequencing: idle -> evaluate (scan words) -> commit
   ba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bitmap memory, hint, free count and response register
   ba_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req.operation),
      .req_block_index  (req.block_index),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_result_index (rsp.result_index),
      .rsp_status       (rsp.status),
      .rsp_free_blocks  (rsp.free_blocks)
   );

endmodule

`default_nettype wire
